FILE: rtl/tec_pkg.sv
// Shared constants and types for the triangle edge coverage unit.
`default_nettype none

package tec_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int COORD_BITS = 12;
	localparam int SLOT_W     = 3;
	localparam int MASK_W     = 8;
	localparam int EDGE_COUNT = 3;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * COORD_BITS + 1;
	localparam int CONST_W    = 2 * COORD_BITS + 2;
	localparam int EVAL_W     = 2 * COORD_BITS + 4;
	localparam int HIT_W      = (SLOT_COUNT > MASK_W) ? SLOT_COUNT : MASK_W;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0]  a;
		logic signed [DIFF_W-1:0]  b;
		logic signed [CONST_W-1:0] c;
	} edge_coef_t;

	typedef struct packed {
		logic                               en;
		logic [SLOT_W-1:0]                  slot;
		edge_coef_t [EDGE_COUNT-1:0]        coef;
	} slot_load_t;

endpackage

`default_nettype wire

FILE: rtl/tec_edge_setup.sv
// Edge equation setup for one triangle edge, oriented toward the opposite vertex.
`default_nettype none

module tec_edge_setup (
	input  tec_pkg::point_t     vs,
	input  tec_pkg::point_t     ve,
	input  tec_pkg::point_t     vo,
	output tec_pkg::edge_coef_t coef
);

	logic signed [tec_pkg::DIFF_W-1:0]  dx;
	logic signed [tec_pkg::DIFF_W-1:0]  dy;
	logic signed [tec_pkg::DIFF_W-1:0]  a_raw;
	logic signed [tec_pkg::DIFF_W-1:0]  b_raw;
	logic signed [tec_pkg::PROD_W-1:0]  prod_xa;
	logic signed [tec_pkg::PROD_W-1:0]  prod_yb;
	logic signed [tec_pkg::CONST_W-1:0] c_raw;
	logic signed [tec_pkg::PROD_W-1:0]  opp_xa;
	logic signed [tec_pkg::PROD_W-1:0]  opp_yb;
	logic signed [tec_pkg::EVAL_W-1:0]  opp_score;
	logic                               flip;

	assign dx    = tec_pkg::DIFF_W'(ve.x) - tec_pkg::DIFF_W'(vs.x);
	assign dy    = tec_pkg::DIFF_W'(ve.y) - tec_pkg::DIFF_W'(vs.y);
	assign a_raw = -dy;
	assign b_raw = dx;

	assign prod_xa = tec_pkg::PROD_W'(vs.x) * tec_pkg::PROD_W'(a_raw);
	assign prod_yb = tec_pkg::PROD_W'(vs.y) * tec_pkg::PROD_W'(b_raw);
	assign c_raw   = -tec_pkg::CONST_W'(prod_xa) - tec_pkg::CONST_W'(prod_yb);

	// score the opposite vertex; flip the edge so the interior is non-negative
	assign opp_xa    = tec_pkg::PROD_W'(vo.x) * tec_pkg::PROD_W'(a_raw);
	assign opp_yb    = tec_pkg::PROD_W'(vo.y) * tec_pkg::PROD_W'(b_raw);
	assign opp_score = tec_pkg::EVAL_W'(opp_xa) + tec_pkg::EVAL_W'(opp_yb)
		+ tec_pkg::EVAL_W'(c_raw);
	assign flip      = opp_score[tec_pkg::EVAL_W-1];

	assign coef.a = flip ? -a_raw : a_raw;
	assign coef.b = flip ? -b_raw : b_raw;
	assign coef.c = flip ? -c_raw : c_raw;

endmodule

`default_nettype wire

FILE: rtl/tec_slot_table.sv
// Triangle slot table: edge coefficient storage and parallel pixel test of all slots.
`default_nettype none

module tec_slot_table (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  tec_pkg::slot_load_t                 wr,
	input  tec_pkg::point_t                     pixel,
	output logic [tec_pkg::SLOT_COUNT-1:0]      hit
);

	tec_pkg::edge_coef_t [tec_pkg::EDGE_COUNT-1:0] coef_q [tec_pkg::SLOT_COUNT];
	logic [tec_pkg::SLOT_COUNT-1:0]                valid_q;
	logic [tec_pkg::SLOT_COUNT-1:0]                sel;

	always_comb begin
		for (int s = 0; s < tec_pkg::SLOT_COUNT; s++) begin
			sel[s] = wr.en && (int'(wr.slot) == s);
		end
	end

	// coefficients are only read behind a valid bit, so they need no reset
	always_ff @(posedge clk) begin
		for (int s = 0; s < tec_pkg::SLOT_COUNT; s++) begin
			if (sel[s]) begin
				coef_q[s] <= wr.coef;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_q | sel;
		end
	end

	for (genvar s = 0; s < tec_pkg::SLOT_COUNT; s++) begin : g_slot
		logic [tec_pkg::EDGE_COUNT-1:0] nonneg;
		for (genvar k = 0; k < tec_pkg::EDGE_COUNT; k++) begin : g_edge
			logic signed [tec_pkg::PROD_W-1:0] pa;
			logic signed [tec_pkg::PROD_W-1:0] pb;
			logic signed [tec_pkg::EVAL_W-1:0] score;
			assign pa = tec_pkg::PROD_W'(coef_q[s][k].a) * tec_pkg::PROD_W'(pixel.x);
			assign pb = tec_pkg::PROD_W'(coef_q[s][k].b) * tec_pkg::PROD_W'(pixel.y);
			assign score = tec_pkg::EVAL_W'(pa) + tec_pkg::EVAL_W'(pb)
				+ tec_pkg::EVAL_W'(coef_q[s][k].c);
			assign nonneg[k] = ~score[tec_pkg::EVAL_W-1];
		end
		assign hit[s] = valid_q[s] & (&nonneg);
	end

endmodule

`default_nettype wire

FILE: rtl/triangle_edge_coverage_unit.sv
// Top level of the triangle edge coverage unit: input stage, edge setup, slot table, result stage.
//
//  channel   handshake              payload
//  -------   ---------------------  ----------------------------------------------
//  command   start / busy           op, slot, vertex0..2 x/y, pixel_x, pixel_y
//  result    done (one-cycle pulse) covered, top_slot, cover_mask
//
// One transaction per cycle: busy stays low. A taken command passes the input register,
// then the result register, which raises its result strobe and presents the result.
// All slots and all edges of each slot are evaluated in parallel, so the
// rate is set by nothing but the clock; a load updates the table as it leaves the
// input register, so a query right behind it already sees the new triangle.
// Reset clears the slot valid bits and the strobe; coefficients need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module triangle_edge_coverage_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire                                  op,
	input  wire  [tec_pkg::SLOT_W-1:0]           slot,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] vertex0_x,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] vertex0_y,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] vertex1_x,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] vertex1_y,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] vertex2_x,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] vertex2_y,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] pixel_x,
	input  wire  signed [tec_pkg::COORD_BITS-1:0] pixel_y,
	output logic                                 done,
	output logic                                 covered,
	output logic [tec_pkg::SLOT_W-1:0]           top_slot,
	output logic [tec_pkg::MASK_W-1:0]           cover_mask
);

	// input stage
	logic                                   valid_s1;
	logic                                   op_s1;
	logic [tec_pkg::SLOT_W-1:0]             slot_s1;
	tec_pkg::point_t [tec_pkg::EDGE_COUNT-1:0] vtx_s1;
	tec_pkg::point_t                        pix_s1;

	// result stage
	logic                                   done_s2;
	logic                                   covered_s2;
	logic [tec_pkg::SLOT_W-1:0]             top_slot_s2;
	logic [tec_pkg::MASK_W-1:0]             cover_mask_s2;

	tec_pkg::slot_load_t                    wr;
	logic [tec_pkg::SLOT_COUNT-1:0]         hit;
	logic [tec_pkg::HIT_W-1:0]              hit_ext;
	logic                                   any_hit;
	logic [tec_pkg::SLOT_W-1:0]             top_d;
	logic                                   accept;
	logic                                   is_load;

	// every cycle can take a command
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// payload of the input stage; hold when nothing is taken
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			slot_s1     <= slot;
			vtx_s1[0].x <= vertex0_x;
			vtx_s1[0].y <= vertex0_y;
			vtx_s1[1].x <= vertex1_x;
			vtx_s1[1].y <= vertex1_y;
			vtx_s1[2].x <= vertex2_x;
			vtx_s1[2].y <= vertex2_y;
			pix_s1.x    <= pixel_x;
			pix_s1.y    <= pixel_y;
		end
	end

	assign is_load = (op_s1 == tec_pkg::OP_LOAD);

	// edge k runs from vertex k+1 to vertex k+2 and is scored against vertex k
	for (genvar k = 0; k < tec_pkg::EDGE_COUNT; k++) begin : g_setup
		tec_edge_setup u_setup (
			.vs   (vtx_s1[(k + 1) % tec_pkg::EDGE_COUNT]),
			.ve   (vtx_s1[(k + 2) % tec_pkg::EDGE_COUNT]),
			.vo   (vtx_s1[k]),
			.coef (wr.coef[k])
		);
	end

	// loads to slots past the table never match a slot and drop out there
	assign wr.en   = valid_s1 && is_load;
	assign wr.slot = slot_s1;

	tec_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pixel  (pix_s1),
		.hit    (hit)
	);

	// highest covering slot wins
	always_comb begin
		top_d = '0;
		for (int s = 0; s < tec_pkg::SLOT_COUNT; s++) begin
			if (hit[s]) begin
				top_d = tec_pkg::SLOT_W'(s);
			end
		end
	end

	assign any_hit = |hit;
	assign hit_ext = tec_pkg::HIT_W'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	// loads report all zeros
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			covered_s2    <= !is_load && any_hit;
			top_slot_s2   <= is_load ? '0 : top_d;
			cover_mask_s2 <= is_load ? '0 : hit_ext[tec_pkg::MASK_W-1:0];
		end
	end

	assign done       = done_s2;
	assign covered    = done_s2 && covered_s2;
	assign top_slot   = top_slot_s2;
	assign cover_mask = cover_mask_s2;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("result strobe missing after input stage");

	a_no_cover_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !covered) |-> (cover_mask == '0 && top_slot == '0))
		else $error("uncovered result carries a slot or mask");

	a_mask_implies_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cover_mask != '0) |-> covered)
		else $error("mask set without covered flag");

	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(accept && op == tec_pkg::OP_LOAD, 2)) |-> !covered)
		else $error("load result reports coverage");

endmodule

`default_nettype wire

FILE: tb/triangle_edge_coverage_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the triangle edge coverage unit: slot table model and per-field result check.
module triangle_edge_coverage_checker
	import tec_pkg::*;
(
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire                         busy,
	input  wire                         op,
	input  wire  [SLOT_W-1:0]           slot,
	input  wire  signed [COORD_BITS-1:0] vertex0_x,
	input  wire  signed [COORD_BITS-1:0] vertex0_y,
	input  wire  signed [COORD_BITS-1:0] vertex1_x,
	input  wire  signed [COORD_BITS-1:0] vertex1_y,
	input  wire  signed [COORD_BITS-1:0] vertex2_x,
	input  wire  signed [COORD_BITS-1:0] vertex2_y,
	input  wire  signed [COORD_BITS-1:0] pixel_x,
	input  wire  signed [COORD_BITS-1:0] pixel_y,
	input  wire                         done,
	input  wire                         covered,
	input  wire  [SLOT_W-1:0]           top_slot,
	input  wire  [MASK_W-1:0]           cover_mask,
	output int                          fail_count,
	output int                          pending
);

	typedef struct packed {
		logic              covered;
		logic [SLOT_W-1:0] top;
		logic [MASK_W-1:0] mask;
	} coverage_t;

	longint    edge_a [SLOT_COUNT*EDGE_COUNT];
	longint    edge_b [SLOT_COUNT*EDGE_COUNT];
	longint    edge_c [SLOT_COUNT*EDGE_COUNT];
	bit        slot_live [SLOT_COUNT];
	coverage_t coverage_due [$];
	int        mismatches = 0;

	// Build the edge equations of the triangle; flip an edge that scores its opposite vertex below zero.
	function automatic void store_triangle(int s, longint x0, longint y0, longint x1,
			longint y1, longint x2, longint y2);
		longint vx [EDGE_COUNT];
		longint vy [EDGE_COUNT];
		longint a, b, c;
		int     st, en;
		vx[0] = x0; vy[0] = y0;
		vx[1] = x1; vy[1] = y1;
		vx[2] = x2; vy[2] = y2;
		for (int k = 0; k < EDGE_COUNT; k++) begin
			st = (k + 1) % EDGE_COUNT;
			en = (k + 2) % EDGE_COUNT;
			a = -(vy[en] - vy[st]);
			b = vx[en] - vx[st];
			c = -(vx[st] * a) - (vy[st] * b);
			if (a * vx[k] + b * vy[k] + c < 0) begin
				a = -a;
				b = -b;
				c = -c;
			end
			edge_a[s*EDGE_COUNT+k] = a;
			edge_b[s*EDGE_COUNT+k] = b;
			edge_c[s*EDGE_COUNT+k] = c;
		end
		slot_live[s] = 1'b1;
	endfunction

	function automatic coverage_t predict_coverage(longint qx, longint qy);
		coverage_t r;
		bit        hit;
		int        e;
		r = '0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			hit = slot_live[s];
			for (int k = 0; k < EDGE_COUNT; k++) begin
				e = s * EDGE_COUNT + k;
				if (hit && edge_a[e] * qx + edge_b[e] * qy + edge_c[e] < 0)
					hit = 1'b0;
			end
			if (hit) begin
				r.covered = 1'b1;
				r.top     = SLOT_W'(s);
				if (s < MASK_W)
					r.mask[s] = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		coverage_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT * EDGE_COUNT; i++) begin
				edge_a[i] = 0;
				edge_b[i] = 0;
				edge_c[i] = 0;
			end
			for (int s = 0; s < SLOT_COUNT; s++)
				slot_live[s] = 1'b0;
			coverage_due.delete();
			pending    <= 0;
			fail_count <= mismatches;
		end else begin
			// retire the oldest expectation before taking a new one
			if (done) begin
				if (coverage_due.size() == 0) begin
					report($sformatf("result with nothing expected: covered %0d top %0d mask %02h",
						covered, top_slot, cover_mask));
				end else begin
					want = coverage_due.pop_front();
					if (covered !== want.covered)
						report($sformatf("covered: expected %0d, got %0d", want.covered, covered));
					if (top_slot !== want.top)
						report($sformatf("top_slot: expected %0d, got %0d", want.top, top_slot));
					if (cover_mask !== want.mask)
						report($sformatf("cover_mask: expected %02h, got %02h", want.mask,
							cover_mask));
				end
			end
			if (start && !busy) begin
				if (op == OP_QUERY) begin
					coverage_due.push_back(predict_coverage(pixel_x, pixel_y));
				end else begin
					if (slot < SLOT_COUNT)
						store_triangle(slot, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
							vertex2_x, vertex2_y);
					coverage_due.push_back('0);
				end
			end
			pending    <= coverage_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: tb/triangle_edge_coverage_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the triangle edge coverage unit: clock, reset, command stimulus, verdict.
module triangle_edge_coverage_unit_tb
	import tec_pkg::*;
;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         op;
	logic [SLOT_W-1:0]            slot;
	logic signed [COORD_BITS-1:0] vertex0_x, vertex0_y;
	logic signed [COORD_BITS-1:0] vertex1_x, vertex1_y;
	logic signed [COORD_BITS-1:0] vertex2_x, vertex2_y;
	logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
	logic                         done;
	logic                         covered;
	logic [SLOT_W-1:0]            top_slot;
	logic [MASK_W-1:0]            cover_mask;
	int                           fail_count;
	int                           pending;

	// Vertices last loaded per slot, kept only to aim queries at real triangles.
	int aim_x [SLOT_COUNT][3];
	int aim_y [SLOT_COUNT][3];
	bit aim_ok [SLOT_COUNT];
	// Set during the stretch where the command side never idles.
	bit quiet;

	triangle_edge_coverage_unit i_dut (
		.clk, .arst_n, .start, .busy, .op, .slot,
		.vertex0_x, .vertex0_y, .vertex1_x, .vertex1_y, .vertex2_x, .vertex2_y,
		.pixel_x, .pixel_y, .done, .covered, .top_slot, .cover_mask
	);

	triangle_edge_coverage_checker i_checker (
		.clk, .arst_n, .start, .busy, .op, .slot,
		.vertex0_x, .vertex0_y, .vertex1_x, .vertex1_y, .vertex2_x, .vertex2_y,
		.pixel_x, .pixel_y, .done, .covered, .top_slot, .cover_mask,
		.fail_count, .pending
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin
		#200000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int rand_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Saturate to the signed coordinate range.
	function automatic int clip(int v);
		if (v > 2047)
			return 2047;
		if (v < -2048)
			return -2048;
		return v;
	endfunction

	// Drive one command and hold it until the transaction is taken.
	task automatic issue(op_t kind, int s, int x0, int y0, int x1, int y1, int x2, int y2,
			int px, int py);
		// random one-cycle gap ahead of this command, except during the quiet stretch
		if (!quiet && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		op        <= kind;
		slot      <= SLOT_W'(s);
		vertex0_x <= COORD_BITS'(x0);
		vertex0_y <= COORD_BITS'(y0);
		vertex1_x <= COORD_BITS'(x1);
		vertex1_y <= COORD_BITS'(y1);
		vertex2_x <= COORD_BITS'(x2);
		vertex2_y <= COORD_BITS'(y2);
		pixel_x   <= COORD_BITS'(px);
		pixel_y   <= COORD_BITS'(py);
		if (kind == OP_LOAD) begin
			aim_x[s][0] = x0; aim_y[s][0] = y0;
			aim_x[s][1] = x1; aim_y[s][1] = y1;
			aim_x[s][2] = x2; aim_y[s][2] = y2;
			aim_ok[s]   = 1'b1;
		end
		do
			@(posedge clk);
		while (busy);
	endtask

	// Load with random pixel fields, so those bits toggle on loads too.
	task automatic load_tri(int s, int x0, int y0, int x1, int y1, int x2, int y2);
		issue(OP_LOAD, s, x0, y0, x1, y1, x2, y2, rand_coord(), rand_coord());
	endtask

	// Query with random slot and vertex fields; the block must ignore them.
	task automatic query_at(int px, int py);
		issue(OP_QUERY, $urandom_range(0, 7), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), px, py);
	endtask

	task automatic random_load();
		int s, r, cx, cy, x0, y0, x1, y1, x2, y2, dx, dy;
		s  = $urandom_range(0, SLOT_COUNT - 1);
		r  = $urandom_range(0, 99);
		cx = jitter(1800);
		cy = jitter(1800);
		x0 = clip(cx + jitter(200)); y0 = clip(cy + jitter(200));
		x1 = clip(cx + jitter(200)); y1 = clip(cy + jitter(200));
		x2 = clip(cx + jitter(200)); y2 = clip(cy + jitter(200));
		if (r >= 60 && r < 80) begin
			// spread over the whole plane, full-width coefficients
			x0 = rand_coord(); y0 = rand_coord();
			x1 = rand_coord(); y1 = rand_coord();
			x2 = rand_coord(); y2 = rand_coord();
		end else if (r >= 80 && r < 90) begin
			// repeated vertex
			x1 = x0;
			y1 = y0;
		end else if (r >= 90) begin
			// collinear vertices
			dx = jitter(100);
			dy = jitter(100);
			x1 = clip(x0 + dx);     y1 = clip(y0 + dy);
			x2 = clip(x0 + 2 * dx); y2 = clip(y0 + 2 * dy);
		end
		load_tri(s, x0, y0, x1, y1, x2, y2);
	endtask

	task automatic random_query();
		int s, r, k, px, py;
		s = $urandom_range(0, SLOT_COUNT - 1);
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 2);
		if (aim_ok[s] && r < 60) begin
			// near the centroid of a stored triangle
			px = clip((aim_x[s][0] + aim_x[s][1] + aim_x[s][2]) / 3 + jitter(40));
			py = clip((aim_y[s][0] + aim_y[s][1] + aim_y[s][2]) / 3 + jitter(40));
		end else if (aim_ok[s] && r < 75) begin
			// exactly on a stored vertex, where the edges through it score zero
			px = aim_x[s][k];
			py = aim_y[s][k];
		end else begin
			px = rand_coord();
			py = rand_coord();
		end
		query_at(px, py);
	endtask

	initial begin
		quiet     = 1'b0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		op        <= OP_LOAD;
		slot      <= '0;
		vertex0_x <= '0;
		vertex0_y <= '0;
		vertex1_x <= '0;
		vertex1_y <= '0;
		vertex2_x <= '0;
		vertex2_y <= '0;
		pixel_x   <= '0;
		pixel_y   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, edges, vertices, both windings, plane extremes,
		// degenerate and collinear triangles.
		query_at(0, 0);
		load_tri(0, 0, 0, 100, 0, 0, 100);
		query_at(10, 10);
		query_at(50, 0);
		query_at(0, 0);
		query_at(200, 200);
		load_tri(7, -2048, -2048, 2047, -2048, -2048, 2047);
		query_at(-2048, -2048);
		query_at(2047, 2047);
		query_at(0, 0);
		load_tri(1, 0, 0, 0, 100, 100, 0);
		query_at(20, 20);
		load_tri(3, 5, 5, 5, 5, 5, 5);
		query_at(2047, -2048);
		load_tri(4, 0, 0, 10, 10, 20, 20);
		query_at(30, 30);
		query_at(-7, 13);
		load_tri(2, 2047, 2047, -2048, 2047, 2047, -2048);
		query_at(2047, 2047);
		load_tri(6, 2047, 2047, 2047, 2047, 2047, 2047);
		query_at(-2048, 2047);
		load_tri(3, -10, -10, 10, -10, 0, 10);
		query_at(0, 0);

		// Random: loads mostly aimed at local regions, queries mostly aimed at stored triangles.
		for (int n = 0; n < 500; n++) begin
			quiet = (n >= 180 && n < 330);
			if ($urandom_range(0, 99) < 40)
				random_load();
			else
				random_query();
		end

		// Drop start and let the pipeline drain.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tec_pkg.sv
rtl/tec_edge_setup.sv
rtl/tec_slot_table.sv
rtl/triangle_edge_coverage_unit.sv
tb/triangle_edge_coverage_checker.sv
tb/triangle_edge_coverage_unit_tb.sv
